>>> src/lpg_pkg.sv
package lpg_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int PHASE_BITS_DEF = 16;

  localparam int IN_W   = 16;
  localparam int AMP_W  = 16;
  localparam int FREQ_W = 8;
  localparam int OFF_W  = 16;
  localparam int CNT_W  = 16;
  localparam int OUT_W  = 17;
  localparam int MAG_W  = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_X_AMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_AMP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_FREQ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_FREQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd6;

  localparam logic [AMP_W-1:0]  X_AMP_RST  = 16'd32768;
  localparam logic [AMP_W-1:0]  Y_AMP_RST  = 16'd32768;
  localparam logic [FREQ_W-1:0] X_FREQ_RST = 8'd1;
  localparam logic [FREQ_W-1:0] Y_FREQ_RST = 8'd2;
  localparam logic [OFF_W-1:0]  X_OFF_RST  = 16'd16384;
  localparam logic [OFF_W-1:0]  Y_OFF_RST  = 16'd0;
  localparam logic [CNT_W-1:0]  COUNT_RST  = 16'd10000;

  // odd polynomial coefficients of the sine, q30
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598669;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;
  localparam logic [31:0] Q30_ONE = 32'd1073741824;
  localparam logic [32:0] ROUND_HALF = 33'd16384;
  localparam logic [MAG_W-1:0] MAG_MAX = 16'd32768;

  function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[61:30];
  endfunction

endpackage

>>> src/lpg_axis.sv
module lpg_axis #(
  parameter int INDEX_BITS = lpg_pkg::INDEX_BITS_DEF,
  parameter int PHASE_BITS = lpg_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [INDEX_BITS-1:0]           index,
  input  logic [lpg_pkg::FREQ_W-1:0]      freq,
  input  logic [lpg_pkg::OFF_W-1:0]       offset,
  input  logic [lpg_pkg::AMP_W-1:0]       amp,
  input  logic [lpg_pkg::CNT_W-1:0]       count,
  output logic signed [lpg_pkg::OUT_W-1:0] value
);
  import lpg_pkg::*;

  localparam int AW    = FREQ_W + INDEX_BITS;
  localparam int STEPS = AW + PHASE_BITS;

  logic [AW-1:0] prod;

  // long division pipeline, one quotient bit per stage
  logic [CNT_W-1:0]      drem [STEPS];
  logic [AW-1:0]         ddvd [STEPS];
  logic [PHASE_BITS-1:0] dq   [STEPS];
  logic [CNT_W-1:0]      drem_next [STEPS];
  logic [AW-1:0]         ddvd_next [STEPS];
  logic [PHASE_BITS-1:0] dq_next   [STEPS];
  logic [CNT_W:0]        dt   [STEPS];
  logic [CNT_W:0]        dsub [STEPS];
  logic                  dge  [STEPS];

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      if (k == 0) begin
        dt[k] = {{CNT_W{1'b0}}, prod[AW-1]};
        ddvd_next[k] = prod << 1;
        dq_next[k] = '0;
      end else begin
        dt[k] = {drem[k-1], ddvd[k-1][AW-1]};
        ddvd_next[k] = ddvd[k-1] << 1;
        dq_next[k] = dq[k-1] << 1;
      end
      dsub[k] = dt[k] - {1'b0, count};
      dge[k] = dt[k] >= {1'b0, count};
      drem_next[k] = dge[k] ? dsub[k][CNT_W-1:0] : dt[k][CNT_W-1:0];
      dq_next[k][0] = dge[k];
    end
  end

  // phase and quadrant fold
  logic [23:0]           off24;
  logic [PHASE_BITS-1:0] phase;
  logic [29:0]           rf;
  logic [30:0]           r_next;

  always_comb begin
    off24 = {offset, 8'h00};
    phase = dq[STEPS-1] + off24[23 -: PHASE_BITS];
    rf = {phase[PHASE_BITS-3:0], {(32-PHASE_BITS){1'b0}}};
    if (phase[PHASE_BITS-2]) begin
      r_next = Q30_ONE[30:0] - {1'b0, rf};
    end else begin
      r_next = {1'b0, rf};
    end
  end

  logic [30:0] r0, r1, r2, r3, r4, r5;
  logic [1:0]  q0, q1, q2, q3, q4, q5, q6, q7;
  logic [31:0] x2_1, x2_2, x2_3, x2_4;
  logic [31:0] s2, s3, s4, s5, v6;
  logic [MAG_W-1:0] mag7;
  logic [63:0] sq;
  logic [32:0] vr;
  logic [17:0] vs;
  logic [MAG_W-1:0] mag_next;
  logic [31:0] ap;
  logic [MAG_W-1:0] pc;
  logic [OUT_W-1:0] val_next;

  always_comb begin
    sq = {33'd0, r0} * {33'd0, r0};
    vr = {1'b0, v6} + ROUND_HALF;
    vs = vr[32:15];
    mag_next = (vs > {2'b00, MAG_MAX}) ? MAG_MAX : vs[MAG_W-1:0];
    ap = {16'd0, amp} * {16'd0, mag7};
    pc = ap[31:15] > 17'h0ffff ? 16'hffff : ap[30:15];
    val_next = q7[1] ? (OUT_W'(0) - {1'b0, pc}) : {1'b0, pc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= AW'(freq) * AW'(index);
      for (int k = 0; k < STEPS; k++) begin
        drem[k] <= drem_next[k];
        ddvd[k] <= ddvd_next[k];
        dq[k]   <= dq_next[k];
      end
      r0 <= r_next;
      q0 <= phase[PHASE_BITS-1 -: 2];
      x2_1 <= {1'b0, sq[60:30]};
      r1 <= r0;
      q1 <= q0;
      s2 <= SIN_C7 - mul_q30(x2_1, SIN_C9);
      x2_2 <= x2_1;
      r2 <= r1;
      q2 <= q1;
      s3 <= SIN_C5 - mul_q30(x2_2, s2);
      x2_3 <= x2_2;
      r3 <= r2;
      q3 <= q2;
      s4 <= SIN_C3 - mul_q30(x2_3, s3);
      x2_4 <= x2_3;
      r4 <= r3;
      q4 <= q3;
      s5 <= SIN_C1 - mul_q30(x2_4, s4);
      r5 <= r4;
      q5 <= q4;
      v6 <= mul_q30({1'b0, r5}, s5);
      q6 <= q5;
      mag7 <= mag_next;
      q7 <= q6;
      value <= signed'(val_next);
    end
  end

endmodule

>>> src/lissajous_point_generator_unit.sv
// lissajous point generator
// input channel: point_index with in_valid/in_ready; one word in gives one
// word out on out_valid/out_ready carrying x_value and y_value, signed q2.15
// configuration channel: cfg_index selects the register, cfg_data is written
// when cfg_valid is high; cfg_ready is always high
// the result passes through the product register, the bit-per-stage phase
// divider and the sine polynomial, rounding, scaling and output stages
// throughput is one word per cycle unless the receiver stalls, the pipeline has no feedback
// when the receiver stalls with a word waiting at the output, the whole
// pipeline holds, bubbles included, and in_ready drops until it is taken
// reset empties the pipeline and loads every register with its default:
// amplitudes 1.0, frequencies 1 and 2, offsets a quarter turn and zero,
// 10000 points per period
module lissajous_point_generator_unit #(
  parameter int INDEX_BITS = lpg_pkg::INDEX_BITS_DEF,
  parameter int PHASE_BITS = lpg_pkg::PHASE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lpg_pkg::IN_W-1:0]         point_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [lpg_pkg::OUT_W-1:0] x_value,
  output logic signed [lpg_pkg::OUT_W-1:0] y_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);
  import lpg_pkg::*;

  localparam int LAT = FREQ_W + INDEX_BITS + PHASE_BITS + 10;

  logic [AMP_W-1:0]  x_amp, y_amp;
  logic [FREQ_W-1:0] x_freq, y_freq;
  logic [OFF_W-1:0]  x_off, y_off;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_eff;
  logic [LAT-1:0]    vld;
  logic              en;
  logic [INDEX_BITS-1:0] idx;

  assign cfg_ready = 1'b1;
  assign en = !vld[LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];
  assign count_eff = (count == '0) ? CNT_W'(1) : count;
  assign idx = INDEX_BITS'(point_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_amp <= X_AMP_RST;
      y_amp <= Y_AMP_RST;
      x_freq <= X_FREQ_RST;
      y_freq <= Y_FREQ_RST;
      x_off <= X_OFF_RST;
      y_off <= Y_OFF_RST;
      count <= COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_AMP:  x_amp <= cfg_data;
        REG_Y_AMP:  y_amp <= cfg_data;
        REG_X_FREQ: x_freq <= cfg_data[FREQ_W-1:0];
        REG_Y_FREQ: y_freq <= cfg_data[FREQ_W-1:0];
        REG_X_OFF:  x_off <= cfg_data;
        REG_Y_OFF:  y_off <= cfg_data;
        REG_COUNT:  count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  lpg_axis #(.INDEX_BITS(INDEX_BITS), .PHASE_BITS(PHASE_BITS)) u_x (
    .clk(clk), .en(en), .index(idx), .freq(x_freq), .offset(x_off),
    .amp(x_amp), .count(count_eff), .value(x_value)
  );

  lpg_axis #(.INDEX_BITS(INDEX_BITS), .PHASE_BITS(PHASE_BITS)) u_y (
    .clk(clk), .en(en), .index(idx), .freq(y_freq), .offset(y_off),
    .amp(y_amp), .count(count_eff), .value(y_value)
  );

endmodule

>>> tb/tb_top.sv
module tb_top;
  import lpg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 50;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_W-1:0] point_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] x_value, y_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_X_AMP;
  logic [15:0] cfg_data = '0;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } point_t;

  // shadow copy of the curve registers
  logic [AMP_W-1:0]  amp_x, amp_y;
  logic [FREQ_W-1:0] freq_x, freq_y;
  logic [OFF_W-1:0]  off_x, off_y;
  logic [CNT_W-1:0]  curve_len;

  point_t expected_points[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit no_stall = 1'b0;
  bit timed_out = 1'b0;

  lissajous_point_generator_unit dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] sine_mag(input logic [15:0] phase, output bit negative);
    logic [31:0] ph32;
    logic [63:0] r, x2, s, v;
    ph32 = {phase, 16'd0};
    r = {34'd0, ph32[29:0]};
    if (ph32[30]) begin
      r = 64'd1073741824 - r;
    end
    x2 = (r * r) >> 30;
    s = 64'd5026995 - ((x2 * 64'd172272) >> 30);
    s = 64'd85569306 - ((x2 * s) >> 30);
    s = 64'd693598669 - ((x2 * s) >> 30);
    s = 64'd1686629713 - ((x2 * s) >> 30);
    v = (r * s) >> 30;
    v = (v + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    negative = ph32[31];
    return v[15:0];
  endfunction

  function automatic logic [OUT_W-1:0] axis_coord(input logic [15:0] idx,
      input logic [7:0] freq, input logic [15:0] offset, input logic [15:0] amp,
      input logic [15:0] n);
    logic [63:0] q, prod, nn;
    logic [15:0] phase, mag;
    bit negative;
    nn = (n == 0) ? 64'd1 : {48'd0, n};
    q = ({56'd0, freq} * {48'd0, idx} << 16) / nn;
    phase = q[15:0] + offset;
    mag = sine_mag(phase, negative);
    prod = ({48'd0, amp} * {48'd0, mag}) >> 15;
    if (prod > 64'd65535) begin
      prod = 64'd65535;
    end
    if (negative) begin
      return 17'd0 - prod[16:0];
    end
    return prod[16:0];
  endfunction

  function automatic point_t curve_point(input logic [15:0] idx);
    point_t p;
    p.x = axis_coord(idx, freq_x, off_x, amp_x, curve_len);
    p.y = axis_coord(idx, freq_y, off_y, amp_y, curve_len);
    return p;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    while (expected_points.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_X_AMP:  amp_x = data;
      REG_Y_AMP:  amp_y = data;
      REG_X_FREQ: freq_x = data[7:0];
      REG_Y_FREQ: freq_y = data[7:0];
      REG_X_OFF:  off_x = data;
      REG_Y_OFF:  off_y = data;
      REG_COUNT:  curve_len = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_index(input logic [15:0] idx);
    @(negedge clk);
    in_valid <= 1'b1;
    point_index <= idx;
    do @(posedge clk); while (!in_ready);
    expected_points.push_back(curve_point(idx));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // bursts: keep valid high across consecutive words
  task automatic send_burst(input int count, input bit directed, input logic [15:0] base);
    logic [15:0] idx;
    for (int k = 0; k < count; k++) begin
      idx = directed ? base + k[15:0] : 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) == 0) begin
        idx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      if (k == 0) begin
        @(negedge clk);
      end
      in_valid <= 1'b1;
      point_index <= idx;
      do @(posedge clk); while (!in_ready);
      expected_points.push_back(curve_point(idx));
      @(negedge clk);
    end
    in_valid <= 1'b0;
    repeat ($urandom_range(0, 6)) @(negedge clk);
  endtask

  task automatic drain;
    while (expected_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_phase(input int bursts);
    for (int b = 0; b < bursts; b++) begin
      send_burst($urandom_range(1, 16), 1'b0, 16'd0);
    end
  endtask

  task automatic test_reset_defaults;
    for (int i = 0; i < 8; i++) begin
      send_index(16'(i * 1250));
    end
    send_index(16'd9999);
    send_index(16'd10000);
    send_index(16'hFFFF);
    drain();
  endtask

  task automatic test_extremes;
    write_reg(REG_X_AMP, 16'hFFFF);
    write_reg(REG_Y_AMP, 16'h0000);
    write_reg(REG_X_FREQ, 16'd255);
    write_reg(REG_Y_FREQ, 16'd0);
    write_reg(REG_X_OFF, 16'hFFFF);
    write_reg(REG_Y_OFF, 16'h4000);
    write_reg(REG_COUNT, 16'd1);
    send_index(16'd0);
    send_index(16'hFFFF);
    send_index(16'h5555);
    write_reg(REG_COUNT, 16'd0);
    send_index(16'hAAAA);
    send_index(16'd1);
    write_reg(REG_COUNT, 16'hFFFF);
    write_reg(REG_Y_AMP, 16'hFFFF);
    write_reg(REG_Y_FREQ, 16'd255);
    send_index(16'hFFFF);
    send_index(16'h8000);
    send_index(16'd1);
    write_reg(REG_X_OFF, 16'h8000);
    write_reg(REG_Y_OFF, 16'hC000);
    send_index(16'd0);
    drain();
  endtask

  task automatic test_random_settings;
    for (int s = 0; s < 11; s++) begin
      write_reg(REG_X_AMP, 16'($urandom_range(0, 65535)));
      write_reg(REG_Y_AMP, 16'($urandom_range(0, 65535)));
      write_reg(REG_X_FREQ, 16'($urandom_range(0, 255)));
      write_reg(REG_Y_FREQ, 16'($urandom_range(0, 255)));
      write_reg(REG_X_OFF, 16'($urandom_range(0, 65535)));
      write_reg(REG_Y_OFF, 16'($urandom_range(0, 65535)));
      write_reg(REG_COUNT, (s % 3 == 0) ? 16'($urandom_range(0, 255))
                                        : 16'($urandom_range(0, 65535)));
      random_phase(10);
      drain();
    end
  endtask

  task automatic test_backpressure;
    long_hold = 1'b1;
    send_burst(80, 1'b1, 16'd100);
    drain();
    no_stall = 1'b1;
    send_burst(120, 1'b0, 16'd0);
    drain();
    no_stall = 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        hold = 0;
        while (hold < 150) begin
          @(negedge clk);
          hold++;
        end
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (no_stall) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // output check
  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word x=%0d y=%0d", x_value, y_value);
        end
      end else begin
        want = expected_points.pop_front();
        if (want.x !== x_value || want.y !== y_value) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch x exp %0d got %0d, y exp %0d got %0d",
                     want.x, x_value, want.y, y_value);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || (!in_valid && expected_points.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    amp_x = X_AMP_RST;
    amp_y = Y_AMP_RST;
    freq_x = X_FREQ_RST;
    freq_y = Y_FREQ_RST;
    off_x = X_OFF_RST;
    off_y = Y_OFF_RST;
    curve_len = COUNT_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_extremes();
    test_backpressure();
    test_random_settings();
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/lpg_pkg.sv
src/lpg_axis.sv
src/lissajous_point_generator_unit.sv
tb/tb_top.sv
